// ----- rtl/lbpu_pkg.sv -----
package lbpu_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W  = 8;
  localparam int BIN_W  = 6;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam logic [BIN_W-1:0] BIN_MAX = 6'd58;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd1024;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // result queue
  localparam int RES_PER_ITEM = 4;
  localparam int RES_DEPTH    = 16;
  localparam int RES_PTR_W    = $clog2(RES_DEPTH);
  localparam int RES_CNT_W    = RES_PTR_W + 1;

  // window[row][col], row 0 = upper, col 0 = two columns back
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic             last;
    logic             fend;
  } res_t;

  typedef struct packed {
    logic [2:0]                   cnt;
    res_t [RES_PER_ITEM-1:0]      ent;
  } push_t;

  typedef logic [255:0][BIN_W-1:0] bin_lut_t;

  // at most two circular bit changes
  function automatic logic uniform_f(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] d;
    int               n;
    d = v ^ {v[0], v[PIX_W-1:1]};
    n = $countones(d);
    return n <= 2;
  endfunction

  function automatic bin_lut_t build_bin_lut();
    bin_lut_t         lut;
    logic [BIN_W-1:0] rank;
    logic [PIX_W-1:0] v;
    lut  = '0;
    rank = '0;
    for (int i = 0; i < 256; i++) begin
      v = PIX_W'(i);
      if (uniform_f(v)) begin
        rank   = rank + 6'd1;
        lut[i] = rank;
      end
    end
    return lut;
  endfunction

  localparam bin_lut_t BIN_LUT = build_bin_lut();

  // neighbors clockwise from top-left, bit k set when neighbor >= center
  function automatic logic [PIX_W-1:0] lbp_f(input win_t w, input int rt, input int rm,
                                              input int rb, input int cl, input int cm,
                                              input int cr);
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] code;
    ctr     = w[rm][cm];
    code[0] = w[rt][cl] >= ctr;
    code[1] = w[rt][cm] >= ctr;
    code[2] = w[rt][cr] >= ctr;
    code[3] = w[rm][cr] >= ctr;
    code[4] = w[rb][cr] >= ctr;
    code[5] = w[rb][cm] >= ctr;
    code[6] = w[rb][cl] >= ctr;
    code[7] = w[rm][cl] >= ctr;
    return code;
  endfunction

endpackage

// ----- rtl/lbpu_ram.sv -----
module lbpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lbpu_res_fifo.sv -----
module lbpu_res_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbpu_pkg::push_t            push_i,
  input  logic                       pop_i,
  output lbpu_pkg::res_t             head_o,
  output logic [lbpu_pkg::RES_CNT_W-1:0] count_o
);

  import lbpu_pkg::*;

  res_t                 buf_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] count_q, count_d;

  // up to four writes a cycle, one read
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      if (3'(k) < push_i.cnt) begin
        buf_q[wr_ptr_q + RES_PTR_W'(k)] <= push_i.ent[k];
      end
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop_i);
    count_d  = count_q + RES_CNT_W'(push_i.cnt) - RES_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- rtl/lbp_3x3_uniform_mapper.sv -----
// 3x3 local binary pattern with 59-bin uniform mapping, streaming.
//
// Input channel: one 8-bit grey pixel per transfer (in_valid_i / in_stall_o),
// raster order. Output channel (out_valid_o / out_stall_i): per pixel the raw
// LBP code, its uniform bin (1..58, 0 = non-uniform), last_in_run_o on the
// final result caused by an input transfer, frame_end_o on the bottom-right
// pixel. A result leaves once its clamped lower-right neighbor is in; one
// input causes 0 to 4 results.
// Config port (cfg_valid_i / cfg_ready_o, always ready): index 0 frame
// width, index 1 frame height. Write only while the block is idle.
// Path: stage 1, stage 2, result queue, output register. Throughput: one
// pixel per cycle while in_stall_o is low; the single output port emits one
// result per cycle while out_stall_i is low, so rows that yield two results
// per pixel (last column, last row) run at that output rate. The line store
// is one RAM, read at the transfer edge and written back in the cycle after.
// Reset: counters, window and queues clear, width/height return to 1024;
// no RAM clearing pass. When the receiver stalls, results pile up in a
// 16-entry queue and in_stall_o rises before it could overflow.
module lbp_3x3_uniform_mapper #(
  parameter int MAX_WIDTH  = lbpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lbpu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lbpu_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lbpu_pkg::PIX_W-1:0]      lbp_code_o,
  output logic [lbpu_pkg::BIN_W-1:0]      uniform_bin_o,
  output logic                            last_in_run_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lbpu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbpu_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import lbpu_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
  localparam int MEM_W  = 2 * PIX_W;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [CNT_W-1:0] addr;
    logic             r0;
    logic             r1;
    logic             c0;
    logic             clast;
    logic             rlast;
  } s1_t;

  // which of the four results an item yields
  typedef struct packed {
    logic g0;     // row above
    logic g1;     // own row, last row only
    logic s0;     // column behind
    logic s1;     // own column, last column only
  } sel_t;

  // ---------------- configuration
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize as the maximum
  logic [WEFF_W-1:0] w_eff;
  logic [HEFF_W-1:0] h_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HEFF_W'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(frame_height_q);
    end
  end

  // ---------------- position and accept
  logic [CNT_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic             c_last, r_last;
  logic             in_accept;

  logic                 s1_valid_q;
  s1_t                  s1_q;
  logic                 s2_valid_q;
  sel_t                 s2_q;
  logic [RES_CNT_W-1:0] fifo_count;
  logic [RES_CNT_W:0]   budget;

  // room for everything in flight plus one more item at four results
  always_comb begin
    budget = RES_CNT_W'(fifo_count) + (RES_CNT_W+1)'(0);
    if (s1_valid_q) budget = budget + (RES_CNT_W+1)'(RES_PER_ITEM);
    if (s2_valid_q) budget = budget + (RES_CNT_W+1)'(RES_PER_ITEM);
  end

  assign in_stall_o = budget > (RES_CNT_W+1)'(RES_DEPTH - RES_PER_ITEM);
  assign in_accept  = in_valid_i && !in_stall_o;

  // counters beyond a shrunk bound act as the last column / row
  always_comb begin
    c      = (WEFF_W'(col_q) < w_eff) ? col_q : CNT_W'(w_eff - WEFF_W'(1));
    r      = (HEFF_W'(row_q) < h_eff) ? row_q : ROW_W'(h_eff - HEFF_W'(1));
    c_last = WEFF_W'(c) == (w_eff - WEFF_W'(1));
    r_last = HEFF_W'(r) == (h_eff - HEFF_W'(1));
    if (c_last) begin
      col_d = '0;
      row_d = r_last ? '0 : r + ROW_W'(1);
    end else begin
      col_d = c + CNT_W'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- line store: {upper, middle} per column
  logic             ram_we;
  logic [MEM_W-1:0] ram_wdata;
  logic [MEM_W-1:0] ram_rdata;
  logic [MEM_W-1:0] line_rd;
  logic             fwd_q;
  logic [MEM_W-1:0] fwd_data_q;

  lbpu_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (c),
    .rdata_o (ram_rdata)
  );

  // one-column frames read the entry being written back in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_accept) begin
      fwd_q <= s1_valid_q && (s1_q.addr == c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_data_q <= ram_wdata;
    end
  end

  assign line_rd   = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_we    = s1_valid_q;
  assign ram_wdata = {line_rd[PIX_W-1:0], s1_q.pix};

  // ---------------- stage 1: window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.pix   <= pixel_value_i;
      s1_q.addr  <= c;
      s1_q.r0    <= r == '0;
      s1_q.r1    <= r == ROW_W'(1);
      s1_q.c0    <= c == '0;
      s1_q.clast <= c_last;
      s1_q.rlast <= r_last;
    end
  end

  win_t                       win_q, win_d;
  logic [2:0][PIX_W-1:0]      col_in;

  always_comb begin
    // new column, top to bottom; the first rows repeat their top edge
    if (s1_q.r0) begin
      col_in[0] = s1_q.pix;
      col_in[1] = s1_q.pix;
    end else if (s1_q.r1) begin
      col_in[0] = line_rd[PIX_W-1:0];
      col_in[1] = line_rd[PIX_W-1:0];
    end else begin
      col_in[0] = line_rd[MEM_W-1:PIX_W];
      col_in[1] = line_rd[PIX_W-1:0];
    end
    col_in[2] = s1_q.pix;
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      if (s1_q.c0) begin
        win_d[i][0] = col_in[i];
        win_d[i][1] = col_in[i];
      end else begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[i][2] = col_in[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
      s2_q       <= '0;
    end else begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        win_q   <= win_d;
        s2_q.g0 <= !s1_q.r0;
        s2_q.g1 <= s1_q.rlast;
        s2_q.s0 <= !s1_q.c0;
        s2_q.s1 <= s1_q.clast;
      end
    end
  end

  // ---------------- stage 2: codes, packed into the result queue
  res_t [RES_PER_ITEM-1:0] cand;
  logic [RES_PER_ITEM-1:0] mask;
  push_t                   push;
  res_t                    head;
  logic                    pop;
  logic [2:0]              n;

  always_comb begin
    // order: row above then own row, columns ascending
    mask[0] = s2_valid_q && s2_q.g0 && s2_q.s0;
    mask[1] = s2_valid_q && s2_q.g0 && s2_q.s1;
    mask[2] = s2_valid_q && s2_q.g1 && s2_q.s0;
    mask[3] = s2_valid_q && s2_q.g1 && s2_q.s1;
    cand[0].code = lbp_f(win_q, 0, 1, 2, 0, 1, 2);
    cand[1].code = lbp_f(win_q, 0, 1, 2, 1, 2, 2);
    cand[2].code = lbp_f(win_q, 1, 2, 2, 0, 1, 2);
    cand[3].code = lbp_f(win_q, 1, 2, 2, 1, 2, 2);
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      cand[k].last = mask[k] && ((mask >> (k + 1)) == '0);
      cand[k].fend = 1'b0;
    end
    // bottom-right pixel is only ever the own-row, own-column result
    cand[3].fend = 1'b1;
    push = '0;
    n    = '0;
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      if (mask[k]) begin
        push.ent[n[1:0]] = cand[k];
        n = n + 3'd1;
      end
    end
    push.cnt = n;
  end

  lbpu_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  // ---------------- output register, bin lookup on the way out
  logic                 out_valid_q;
  logic [PIX_W-1:0]     lbp_code_q;
  logic [BIN_W-1:0]     uniform_bin_q;
  logic                 last_q;
  logic                 fend_q;

  assign pop = (fifo_count != '0) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= pop || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      lbp_code_q    <= head.code;
      uniform_bin_q <= BIN_LUT[head.code];
      last_q        <= head.last;
      fend_q        <= head.fend;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lbp_code_o    = lbp_code_q;
  assign uniform_bin_o = uniform_bin_q;
  assign last_in_run_o = last_q;
  assign frame_end_o   = fend_q;

endmodule

// ----- rtl/lbpu_checker.sv -----
module lbpu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [lbpu_pkg::PIX_W-1:0]      lbp_code_o,
  input logic [lbpu_pkg::BIN_W-1:0]      uniform_bin_o,
  input logic                            last_in_run_o,
  input logic                            frame_end_o
);

  import lbpu_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lbp_code_o)
      && $stable(uniform_bin_o) && $stable(last_in_run_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> uniform_bin_o <= BIN_MAX)
    else $error("uniform bin out of range");

  // bin 0 exactly for codes with more than two circular transitions
  a_bin_uniform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((uniform_bin_o == '0) ==
      ($countones(lbp_code_o ^ {lbp_code_o[0], lbp_code_o[PIX_W-1:1]}) > 2)))
    else $error("uniform bin disagrees with code");

  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_in_run_o)
    else $error("frame end not on last result of its input");

endmodule

bind lbp_3x3_uniform_mapper lbpu_checker u_lbpu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .lbp_code_o    (lbp_code_o),
  .uniform_bin_o (uniform_bin_o),
  .last_in_run_o (last_in_run_o),
  .frame_end_o   (frame_end_o)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

// Streaming 3x3 LBP / 59-bin uniform mapper check.
// A scoreboard class mirrors the line stores, the window and the raster
// counters. Every pixel transfer pushes the results it completes. Every
// result transfer is compared field by field against the oldest one.
module testbench;
  import lbpu_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int MAX_WAIT       = 18;
  // first result trails its pixel through the pipeline; leave margin for
  // pixels that complete nothing
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  // longest legal quiet stretch is the long output hold plus a few gaps
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 360;

  // indexes with no register behind them; writes must be dropped
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_3  = 2'd3;
  localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

  // first frame: black/white checker plus a mid grey and a repeated level
  localparam logic [PIX_W-1:0] EXTREME_PX [9] = '{
    8'd0,   8'd255, 8'd0,
    8'd255, 8'd128, 8'd0,
    8'd17,  8'd17,  8'd255
  };

  typedef enum int {
    STYLE_NOISE,
    STYLE_TWO_LEVEL,
    STYLE_FLAT,
    STYLE_RIPPLE
  } pix_style_e;

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic [BIN_W-1:0] bin;
    logic             last;
    logic             fend;
  } lbp_result_t;

  // ---------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic [PIX_W-1:0]      pixel_value_i = '0;
  logic                  out_stall_i   = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      lbp_code_o;
  logic [BIN_W-1:0]      uniform_bin_o;
  logic                  last_in_run_o;
  logic                  frame_end_o;
  logic                  cfg_ready_o;

  lbp_3x3_uniform_mapper u_top (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Scoreboard: LBP predictor plus queue of pending results
  // ---------------------------------------------------------------------
  class lbp_scoreboard;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] upper_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] middle_line[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win[3][3];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    lbp_result_t      expected_q[$];
    int unsigned      n_errors;

    function new();
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      col_cnt    = 0;
      row_cnt    = 0;
      n_errors   = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          win[i][j] = '0;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
      else if (idx == REG_FRAME_HEIGHT) height_reg = data[FH_W-1:0];
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function bit idle();
      return expected_q.size() == 0;
    endfunction

    function int bit_changes(logic [PIX_W-1:0] v);
      int n;
      n = 0;
      for (int k = 0; k < PIX_W; k++)
        if (v[k] != v[(k + 1) % PIX_W]) n++;
      return n;
    endfunction

    // rank among uniform codes in ascending order, 0 if not uniform
    function logic [BIN_W-1:0] uniform_bin_of(logic [PIX_W-1:0] v);
      int rank;
      rank = 0;
      if (bit_changes(v) > 2) return '0;
      for (int u = 0; u <= int'(v); u++)
        if (bit_changes(PIX_W'(u)) <= 2) rank++;
      return BIN_W'(rank);
    endfunction

    // neighbors clockwise from top-left; bit set when neighbor >= center
    function logic [PIX_W-1:0] code_at(int rt, int rm, int rb, int cl, int cm, int cr);
      logic [PIX_W-1:0] ctr;
      logic [PIX_W-1:0] nb[8];
      logic [PIX_W-1:0] code;
      ctr   = win[rm][cm];
      nb[0] = win[rt][cl];
      nb[1] = win[rt][cm];
      nb[2] = win[rt][cr];
      nb[3] = win[rm][cr];
      nb[4] = win[rb][cr];
      nb[5] = win[rb][cm];
      nb[6] = win[rb][cl];
      nb[7] = win[rm][cl];
      for (int k = 0; k < PIX_W; k++) code[k] = nb[k] >= ctr;
      return code;
    endfunction

    function void push_result(logic [PIX_W-1:0] code, int unsigned orow,
                              int unsigned ocol, int unsigned w, int unsigned h);
      lbp_result_t res;
      res.code = code;
      res.bin  = uniform_bin_of(code);
      res.last = 1'b0;
      res.fend = (orow == h - 1) && (ocol == w - 1);
      expected_q.push_back(res);
    endfunction

    // one window row set: column c-1, and column c too on the last column
    function void emit_row(int rt, int rm, int rb, int unsigned orow,
                           int unsigned c, int unsigned w, int unsigned h);
      if (c >= 1) push_result(code_at(rt, rm, rb, 0, 1, 2), orow, c - 1, w, h);
      if (c == w - 1) push_result(code_at(rt, rm, rb, 1, 2, 2), orow, c, w, h);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned      w, h, c, r, n_before;
      logic [PIX_W-1:0] col_in[3];
      lbp_result_t      tail;
      // zero acts as one, oversize acts as the store limits
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = height_reg;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      // counters past a shrunk bound act as the last column / row
      c = (col_cnt < w) ? col_cnt : w - 1;
      r = (row_cnt < h) ? row_cnt : h - 1;

      // rows above clamp to the current one at the top border
      col_in[2] = p;
      if (r == 0) begin
        col_in[0] = p;
        col_in[1] = p;
      end else if (r == 1) begin
        col_in[0] = middle_line[c];
        col_in[1] = middle_line[c];
      end else begin
        col_in[0] = upper_line[c];
        col_in[1] = middle_line[c];
      end
      upper_line[c]  = middle_line[c];
      middle_line[c] = p;

      // left border repeats the first column
      for (int i = 0; i < 3; i++) begin
        if (c == 0) begin
          win[i][0] = col_in[i];
          win[i][1] = col_in[i];
        end else begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[i][2] = col_in[i];
      end

      n_before = expected_q.size();
      if (r >= 1) emit_row(0, 1, 2, r - 1, c, w, h);
      if (r == h - 1) emit_row(1, 2, 2, r, c, w, h);
      if (expected_q.size() > n_before) begin
        tail      = expected_q.pop_back();
        tail.last = 1'b1;
        expected_q.push_back(tail);
      end

      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      n_errors++;
    endtask

    task check_result(logic [PIX_W-1:0] code, logic [BIN_W-1:0] bin,
                      logic last, logic fend);
      lbp_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, code %02h", code));
      end else begin
        want = expected_q.pop_front();
        if (code !== want.code)
          report($sformatf("lbp_code %02h, want %02h", code, want.code));
        if (bin !== want.bin)
          report($sformatf("uniform_bin %0d, want %0d (code %02h)", bin, want.bin, want.code));
        if (last !== want.last)
          report($sformatf("last_in_run %b, want %b", last, want.last));
        if (fend !== want.fend)
          report($sformatf("frame_end %b, want %b", fend, want.fend));
      end
    endtask
  endclass

  lbp_scoreboard sb = new();

  // ---------------------------------------------------------------------
  // Pacing: each side alternates runs of random waits with runs of
  // back-to-back transfers
  // ---------------------------------------------------------------------
  int tx_run_left = 0;
  int rx_run_left = 0;
  bit tx_no_idle  = 1'b0;
  bit rx_no_idle  = 1'b0;
  bit hold_output = 1'b0;  // asks the sink for one long stall
  int pixels_sent = 0;

  logic [PIX_W-1:0] level_a = '0;
  logic [PIX_W-1:0] level_b = '0;

  function automatic int next_wait(ref int run_left, ref bit no_idle);
    if (run_left == 0) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(pix_style_e style);
    case (style)
      STYLE_TWO_LEVEL: return $urandom_range(0, 1) ? level_a : level_b;
      // long runs of equal pixels, so ties with the center are common
      STYLE_FLAT:      return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom) : level_a;
      // +-1 around a level, wrapping through 0 and 255
      STYLE_RIPPLE:    return level_a + PIX_W'($urandom_range(0, 2)) - PIX_W'(1);
      default:         return PIX_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = next_wait(tx_run_left, tx_no_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= p;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // feed until the raster wraps; optionally stop once mid-frame until
  // every pending result is out
  task automatic finish_frame(input pix_style_e style, input int pause_at);
    int n;
    n = 0;
    do begin
      if (n == pause_at) drain();
      send_pixel(pick_pixel(style));
      n++;
    end while (!sb.at_frame_start());
  endtask

  // sender goes quiet until every result is out, then lets the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (!sb.idle()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_val,
                           input logic [CFG_DATA_W-1:0] h_val);
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result sink: random stalls, one long hold on request, checks each
  // accepted transfer
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int wait_cycles;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_output) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        wait_cycles = next_wait(rx_run_left, rx_no_idle);
        if (wait_cycles > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(lbp_code_o, uniform_bin_o, last_in_run_o, frame_end_o);
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any transfer on any channel restarts the count
  // ---------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
          cfg_valid_i === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    pix_style_e                style;
    logic [CFG_DATA_W-1:0]     w_val, h_val;
    int                        frame_no;
    int                        random_start;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes to unused indexes must leave geometry alone
    write_reg(REG_SPARE_2, CFG_ALL_ONES);
    write_reg(REG_SPARE_3, '0);
    // 3x3 frame of extremes: every pixel but the center sees clamped borders
    set_frame(CFG_DATA_W'(3), CFG_DATA_W'(3));
    foreach (EXTREME_PX[i]) send_pixel(EXTREME_PX[i]);
    drain();

    // zero width behaves as a single column
    set_frame(CFG_DATA_W'(0), CFG_DATA_W'(3));
    repeat (3) send_pixel(PIX_W'($urandom));
    drain();

    // zero height behaves as a single row
    set_frame(CFG_DATA_W'(3), CFG_DATA_W'(0));
    repeat (3) send_pixel(PIX_W'($urandom));
    drain();

    // shrink mid-frame: 4x5 frame, stop at row 2 column 2
    set_frame(CFG_DATA_W'(4), CFG_DATA_W'(5));
    repeat (10) send_pixel(PIX_W'($urandom));
    drain();
    // column counter now past the new width: treated as last column, wraps
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    cfg_valid_i <= 1'b0;
    send_pixel(PIX_W'($urandom));
    drain();
    // row counter (3) past the new height: treated as the last row
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    cfg_valid_i <= 1'b0;
    finish_frame(STYLE_NOISE, -1);
    drain();

    // oversize width caps at the line store depth; the start of one row
    // under a long output hold so the result queue backs up, then a
    // narrower width makes the next pixel the last column
    hold_output = 1'b1;
    set_frame(CFG_ALL_ONES, CFG_DATA_W'(1));
    repeat (40) send_pixel(PIX_W'($urandom));
    drain();
    set_frame(CFG_DATA_W'(8), CFG_DATA_W'(1));
    finish_frame(STYLE_NOISE, -1);
    drain();

    // oversize height caps at MAX_HEIGHT: one column, 40 rows, then a
    // smaller height makes the next row the last
    level_a = PIX_W'($urandom);
    set_frame(CFG_DATA_W'(1), CFG_ALL_ONES);
    repeat (40) send_pixel(pick_pixel(STYLE_RIPPLE));
    drain();
    set_frame(CFG_DATA_W'(1), CFG_DATA_W'(2));
    finish_frame(STYLE_RIPPLE, -1);
    drain();

    // random frames, mostly small; geometry changes only between frames
    frame_no     = 0;
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom));
      if (frame_no == 0) begin
        // wide enough to fill the result queue during the long hold
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(24));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(4));
        hold_output = 1'b1;
      end else if ($urandom_range(0, 4) != 0) begin
        w_val = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(0, 12));
        h_val = CFG_DATA_W'((w_val > 12) ? $urandom_range(1, 4) : $urandom_range(0, 8));
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_HEIGHT, h_val);
      end
      cfg_valid_i <= 1'b0;

      style   = pix_style_e'($urandom_range(0, 3));
      level_a = PIX_W'($urandom);
      level_b = ($urandom_range(0, 2) == 0) ? ~level_a : PIX_W'($urandom);
      finish_frame(style, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : -1);
      drain();
      frame_no++;
    end

    drain();
    if (sb.n_errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
